[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion forms, disabled while reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[sv/tpm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_pkg
// Types, register map and sine table for the timed-pulse OOK/FSK modulator.
// ----------------------------------------------------------------------------
package tpm_pkg;

  localparam int unsigned CfgAddrW = 5;

  typedef enum logic [2:0] {
    RegEnable    = 3'd0,
    RegMode      = 3'd1,
    RegDeviation = 3'd2,
    RegEndFirst  = 3'd3,
    RegEndSecond = 3'd4
  } tpm_reg_e;

  typedef enum logic [1:0] {
    ModeOok = 2'd0,
    ModeFsk = 2'd1
  } tpm_mode_e;

  // Phase word handling
  localparam logic [31:0] OokPhaseStep = 32'd200;
  localparam int unsigned PhaseIdxLsb  = 18;
  localparam logic [7:0]  QuarterTurn  = 8'd64;

  typedef struct packed {
    logic               word_available;
    logic signed [31:0] duration_word;
  } tpm_in_t;

  typedef struct packed {
    logic signed [7:0] sample_i;
    logic signed [7:0] sample_q;
    logic              sample_valid;
    logic              word_taken;
    logic              underrun;
    logic              stream_done;
  } tpm_out_t;

  localparam logic [6:0] QuarterSine [65] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
    7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
    7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
    7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
    7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  // Full-turn sine from the quarter table: mirror odd quadrants, negate the
  // second half.
  function automatic logic signed [7:0] sine_lookup(input logic [7:0] idx);
    logic [1:0] quad;
    logic [6:0] pos;
    logic [6:0] amp;
    quad = idx[7:6];
    pos  = quad[0] ? 7'(7'd64 - {1'b0, idx[5:0]}) : {1'b0, idx[5:0]};
    amp  = QuarterSine[pos];
    return quad[1] ? 8'(-$signed({1'b0, amp})) : $signed({1'b0, amp});
  endfunction

endpackage

[sv/timed_pulse_ook_fsk_modulator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timed_pulse_ook_fsk_modulator
// NCO-based on-off keying / two-tone FSK modulator driven by timed pulse words.
// ----------------------------------------------------------------------------
// One request per clock unless the input stalls: each accepted request yields
// exactly one result, held in the output register or, while the output stalls,
// in the skid entry; a two-entry output buffer keeps the input running while a
// result waits. A duration word becomes a run length in a pipeline of registered
// partial products (exact divide by one million through a scaled reciprocal);
// until it lands, constant thresholds on the word's magnitude decide whether the
// run has already ended. The FSK phase step is computed across the setup and
// access cycles of the deviation write. No clearing pass is needed after reset.
module timed_pulse_ook_fsk_modulator #(
  parameter int unsigned SAMPLE_RATE = 2280000
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tpm_pkg::tpm_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tpm_pkg::tpm_out_t             out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpm_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // len = floor(mag * SAMPLE_RATE / 1e6) = floor(mag * LenMult / 2^52)
  localparam logic [79:0] LenMult =
    ((80'(SAMPLE_RATE) << 52) + 80'd999999) / 80'd1000000;
  localparam logic [28:0] LenMultLo = LenMult[28:0];
  localparam logic [27:0] LenMultHi = LenMult[56:29];

  // step = floor((dev << 26) / SAMPLE_RATE) = floor(dev * DevMult / 2^45)
  localparam logic [79:0] DevMult =
    ((80'd1 << 71) + 80'(SAMPLE_RATE) - 80'd1) / 80'(SAMPLE_RATE);
  localparam logic [28:0] DevMultLo = DevMult[28:0];
  localparam logic [25:0] DevMultHi = DevMult[54:29];

  // Largest magnitude whose run length is at most N samples
  localparam logic [31:0] RunThr0 = 32'((64'd1000000 - 64'd1) / 64'(SAMPLE_RATE));
  localparam logic [31:0] RunThr1 = 32'((64'd2000000 - 64'd1) / 64'(SAMPLE_RATE));
  localparam logic [31:0] RunThr2 = 32'((64'd3000000 - 64'd1) / 64'(SAMPLE_RATE));
  localparam logic [31:0] RunThr3 = 32'((64'd4000000 - 64'd1) / 64'(SAMPLE_RATE));

  // Configuration registers
  logic        enable_q;
  logic [1:0]  mode_q;
  logic [19:0] dev_q;
  logic [31:0] end_first_q, end_second_q;
  logic [31:0] step_q;
  logic [19:0] dev_lo_q;

  // Modulator state
  logic        level_q, level_d;
  logic [1:0]  marks_q, marks_d;
  logic        finished_q, finished_d;
  logic [31:0] phase_q, phase_d;
  logic [31:0] run_length_q, run_length_d;
  logic [31:0] run_elapsed_q, run_elapsed_d;

  // Run length pipeline
  logic [2:0]  pend_q, pend_d;
  logic [31:0] mag_hold_q, mag_hold_d;
  logic [31:0] len_lo_q, len_lo2_q;
  logic [59:0] len_prod_q;

  // Output buffer
  logic              out_valid_q, out_valid_d;
  logic              skid_valid_q, skid_valid_d;
  tpm_pkg::tpm_out_t out_data_q, skid_data_q, res;
  logic              out_free;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic        in_fire, active;
  logic [31:0] word_u, mag, marker, thr, base;
  logic        run_over, marker_hit;
  logic [60:0] len_lo_prod, len_sum;
  logic [37:0] len_full;
  logic [31:0] len_sat;
  logic [48:0] dev_lo_prod;
  logic [45:0] dev_hi_prod;
  logic [46:0] dev_sum;
  logic [7:0]  idx_q_ph, idx_i_ph;

  assign pready    = 1'b1;
  assign cfg_idx   = paddr[4:2];
  assign cfg_wr    = psel && penable && pwrite;

  // Deviation step: low partial product in setup, high one in access
  assign dev_lo_prod = pwdata[19:0] * DevMultLo;
  assign dev_hi_prod = pwdata[19:0] * DevMultHi;
  assign dev_sum     = {1'b0, dev_hi_prod} + {27'b0, dev_lo_q};

  always_ff @(posedge clk_i) begin
    dev_lo_q <= dev_lo_prod[48:29];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b0;
      mode_q       <= 2'd0;
      dev_q        <= 20'd0;
      end_first_q  <= 32'd0;
      end_second_q <= 32'd0;
      step_q       <= 32'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tpm_pkg::RegEnable:    enable_q <= pwdata[0];
        tpm_pkg::RegMode:      mode_q   <= pwdata[1:0];
        tpm_pkg::RegDeviation: begin
          dev_q  <= pwdata[19:0];
          step_q <= 32'(dev_sum[46:16]);
        end
        tpm_pkg::RegEndFirst:  end_first_q  <= pwdata;
        tpm_pkg::RegEndSecond: end_second_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      tpm_pkg::RegEnable:    prdata = {31'b0, enable_q};
      tpm_pkg::RegMode:      prdata = {30'b0, mode_q};
      tpm_pkg::RegDeviation: prdata = {12'b0, dev_q};
      tpm_pkg::RegEndFirst:  prdata = end_first_q;
      tpm_pkg::RegEndSecond: prdata = end_second_q;
      default:               prdata = 32'd0;
    endcase
  end

  // Run length: multiply by the scaled reciprocal, then saturate
  assign len_lo_prod = mag_hold_q * LenMultLo;
  assign len_sum     = {1'b0, len_prod_q} + {29'b0, len_lo2_q};
  assign len_full    = len_sum[60:23];
  assign len_sat     = (|len_full[37:32]) ? '1 : len_full[31:0];

  always_ff @(posedge clk_i) begin
    len_lo_q   <= len_lo_prod[60:29];
    len_prod_q <= mag_hold_q * LenMultHi;
    len_lo2_q  <= len_lo_q;
  end

  // Handshake
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !skid_valid_q;
  assign active      = enable_q && !finished_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign word_u = in_data_i.duration_word;
  assign mag    = word_u[31] ? 32'(~word_u + 32'd1) : word_u;
  assign marker = (marks_q == 2'd0) ? end_first_q : end_second_q;
  assign marker_hit = (marks_q < 2'd2) && (word_u == marker);

  always_comb begin
    case (run_elapsed_q[1:0])
      2'd0:    thr = RunThr0;
      2'd1:    thr = RunThr1;
      2'd2:    thr = RunThr2;
      default: thr = RunThr3;
    endcase
  end

  // While the length is still in the pipeline, judge the run by magnitude
  assign run_over = (|pend_q) ? (mag_hold_q <= thr) : (run_length_q <= run_elapsed_q);

  always_comb begin
    level_d       = level_q;
    marks_d       = marks_q;
    finished_d    = finished_q;
    phase_d       = phase_q;
    run_elapsed_d = run_elapsed_q;
    mag_hold_d    = mag_hold_q;
    pend_d        = {pend_q[1:0], 1'b0};
    run_length_d  = pend_q[2] ? len_sat : run_length_q;
    base          = run_elapsed_q;
    idx_q_ph      = 8'd0;
    idx_i_ph      = 8'd0;
    res           = '0;

    if (in_fire && active) begin
      res.sample_valid = 1'b1;
      if (run_over) begin
        // Drop any length still in flight
        run_length_d = 32'd0;
        base         = 32'd0;
        pend_d       = 3'b000;
        if (!in_data_i.word_available) begin
          res.underrun = 1'b1;
        end else begin
          res.word_taken = 1'b1;
          if (marker_hit) begin
            marks_d = marks_q + 2'd1;
            if (marks_q == 2'd1) begin
              finished_d       = 1'b1;
              level_d          = 1'b0;
              res.stream_done  = 1'b1;
            end
          end else begin
            pend_d     = 3'b001;
            mag_hold_d = mag;
            level_d    = !word_u[31];
          end
        end
      end
      run_elapsed_d = (base == '1) ? base : base + 32'd1;

      case (mode_q)
        tpm_pkg::ModeOok: begin
          if (level_d) begin
            phase_d = phase_q + tpm_pkg::OokPhaseStep;
          end
        end
        tpm_pkg::ModeFsk: begin
          phase_d = level_d ? phase_q + step_q : phase_q - step_q;
        end
        default: ;
      endcase

      idx_q_ph = phase_d[tpm_pkg::PhaseIdxLsb +: 8];
      idx_i_ph = idx_q_ph + tpm_pkg::QuarterTurn;
      if ((mode_q == tpm_pkg::ModeFsk) || ((mode_q == tpm_pkg::ModeOok) && level_d)) begin
        res.sample_i = tpm_pkg::sine_lookup(idx_i_ph);
        res.sample_q = tpm_pkg::sine_lookup(idx_q_ph);
      end
    end

    // Re-arm
    if (cfg_wr && (cfg_idx == tpm_pkg::RegEnable) && pwdata[0]) begin
      finished_d = 1'b0;
      marks_d    = 2'd0;
    end
  end

  always_comb begin
    if (out_free) begin
      out_valid_d  = skid_valid_q || in_fire;
      skid_valid_d = 1'b0;
    end else begin
      out_valid_d  = 1'b1;
      skid_valid_d = skid_valid_q || in_fire;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q       <= 1'b0;
      marks_q       <= 2'd0;
      finished_q    <= 1'b0;
      phase_q       <= 32'd0;
      run_length_q  <= 32'd0;
      run_elapsed_q <= 32'd0;
      pend_q        <= 3'b000;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      level_q       <= level_d;
      marks_q       <= marks_d;
      finished_q    <= finished_d;
      phase_q       <= phase_d;
      run_length_q  <= run_length_d;
      run_elapsed_q <= run_elapsed_d;
      pend_q        <= pend_d;
      out_valid_q   <= out_valid_d;
      skid_valid_q  <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_hold_q <= mag_hold_d;
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : res;
    end
    if (!out_free && in_fire) begin
      skid_data_q <= res;
    end
  end

endmodule

[sv/tpm_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpm_checker
// Port-level checks for the timed-pulse OOK/FSK modulator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tpm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input tpm_pkg::tpm_out_t out_data_o
);

  // A held result stays put
  `ASSERT_NXT(out_hold_a, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Every accepted request shows up as a pending result
  `ASSERT_NXT(req_to_out_a, clk_i, rst_ni, in_valid_i && !in_stall_o, out_valid_o)

  // Input only stalls behind a waiting result
  `ASSERT_IMP(stall_full_a, clk_i, rst_ni, in_stall_o, out_valid_o)

  // Idle results carry nothing
  `ASSERT_IMP(idle_zero_a, clk_i, rst_ni, out_valid_o && !out_data_o.sample_valid, out_data_o.sample_i == '0 && out_data_o.sample_q == '0 && !out_data_o.word_taken && !out_data_o.underrun && !out_data_o.stream_done)

  // End of stream consumes the marker word
  `ASSERT_IMP(done_taken_a, clk_i, rst_ni, out_valid_o && out_data_o.stream_done, out_data_o.word_taken && out_data_o.sample_valid && !out_data_o.underrun)

endmodule

bind timed_pulse_ook_fsk_modulator tpm_checker u_tpm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
